// ===== rtl/core/vcp_pkg.sv =====
// ----------------------------------------------------------------------------
// vcp_pkg
// shared types, constants and codes of the voxel camera projection block
// ----------------------------------------------------------------------------
package vcp_pkg;

  localparam int MAX_CAMERAS = 8;
  localparam int FRAC_BITS   = 16;
  localparam int SIZE_BASE   = MAX_CAMERAS * 12;
  localparam int ORIGIN_BASE = SIZE_BASE + 3;
  localparam int TABLE_DEPTH = SIZE_BASE + 6;
  localparam int ADDR_W      = 7;
  localparam int CAM_W       = $clog2(MAX_CAMERAS + 1);
  localparam int PROD_SHIFT  = FRAC_BITS + 1;
  localparam int ACC_W       = 50;
  localparam int DIV_W       = 52;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int STEP_W      = 4;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [2:0] CFG_GRID_X  = 3'd0;
  localparam logic [2:0] CFG_GRID_Y  = 3'd1;
  localparam logic [2:0] CFG_GRID_Z  = 3'd2;
  localparam logic [2:0] CFG_WIDTH   = 3'd3;
  localparam logic [2:0] CFG_HEIGHT  = 3'd4;
  localparam logic [2:0] CFG_CAMERAS = 3'd5;

  typedef struct packed {
    logic              operation;
    logic [6:0]        table_index;
    logic signed [31:0] table_value;
    logic [9:0]        voxel_x;
    logic [9:0]        voxel_y;
    logic [9:0]        voxel_z;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  camera_index;
    logic [23:0] pixel_index;
  } out_item_t;

  typedef struct packed {
    logic [10:0] grid_x;
    logic [10:0] grid_y;
    logic [10:0] grid_z;
    logic [12:0] width;
    logic [12:0] height;
    logic [3:0]  cameras;
  } cfg_t;

  typedef struct packed {
    logic              is_proj;
    logic              wr_ok;
    logic [ADDR_W-1:0] index;
    logic signed [31:0] value;
    logic [9:0]        vx;
    logic [9:0]        vy;
    logic [9:0]        vz;
  } cmd_t;

endpackage

// ===== rtl/core/vcp_front.sv =====
// ----------------------------------------------------------------------------
// vcp_front
// accepts input beats, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module vcp_front import vcp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t data,
  input  logic     cmd_pop,
  output logic     cmd_empty,
  output cmd_t     cmd
);

  cmd_t       q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       do_push, do_pop;

  always_comb begin
    cls.is_proj = (data.operation == OP_PROJECT);
    cls.wr_ok   = ({25'd0, data.table_index} < TABLE_DEPTH);
    cls.index   = data.table_index;
    cls.value   = data.table_value;
    cls.vx      = data.voxel_x;
    cls.vy      = data.voxel_y;
    cls.vz      = data.voxel_z;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_empty = (cnt_r == 2'd0);
  assign cmd       = q_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && !cmd_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (do_pop) rd_r <= !rd_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= cls;
  end

endmodule

// ===== rtl/core/vcp_div.sv =====
// ----------------------------------------------------------------------------
// vcp_div
// two-lane restoring divider sharing one divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vcp_div import vcp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num0,
  input  logic [DIV_W-1:0] num1,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] q0,
  output logic [DIV_W-1:0] q1
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r, done_r;
  logic [DIV_W-1:0]     n0_r, n1_r, q0_r, q1_r, den_r;
  logic [DIV_W:0]       r0_r, r1_r, t0, t1;
  logic                 ge0, ge1;

  assign t0  = {r0_r[DIV_W-1:0], n0_r[DIV_W-1]};
  assign t1  = {r1_r[DIV_W-1:0], n1_r[DIV_W-1]};
  assign ge0 = (t0 >= {1'b0, den_r});
  assign ge1 = (t1 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_CNT_W'(DIV_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n0_r  <= num0;
      n1_r  <= num1;
      den_r <= den;
      r0_r  <= '0;
      r1_r  <= '0;
      q0_r  <= '0;
      q1_r  <= '0;
    end else if (run_r) begin
      n0_r <= {n0_r[DIV_W-2:0], 1'b0};
      n1_r <= {n1_r[DIV_W-2:0], 1'b0};
      r0_r <= ge0 ? t0 - {1'b0, den_r} : t0;
      r1_r <= ge1 ? t1 - {1'b0, den_r} : t1;
      q0_r <= {q0_r[DIV_W-2:0], ge0};
      q1_r <= {q1_r[DIV_W-2:0], ge1};
    end
  end

  assign done = done_r;
  assign q0   = q0_r;
  assign q1   = q1_r;

endmodule

// ===== rtl/core/vcp_res_q.sv =====
// ----------------------------------------------------------------------------
// vcp_res_q
// two-entry result queue between the back end and the result port
// ----------------------------------------------------------------------------
module vcp_res_q import vcp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t din,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output out_item_t dout
);

  out_item_t  q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign dout    = q_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (do_pop) rd_r <= !rd_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= din;
  end

endmodule

// ===== rtl/core/vcp_back.sv =====
// ----------------------------------------------------------------------------
// vcp_back
// table memory and projection sequencer: centre, per-camera mac, divide, test
// ----------------------------------------------------------------------------
module vcp_back import vcp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      res_push,
  output out_item_t res,
  input  logic      res_full
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CENT  = 9'b000000010,
    ST_CCALC = 9'b000000100,
    ST_MAC   = 9'b000001000,
    ST_DEPTH = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_CHECK = 9'b001000000,
    ST_PIX   = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CAM_W-1:0]  cam_r, cam_nxt, cams_r, cam_inc;
  cmd_t              cur_r;

  logic signed [31:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]  rd_addr;
  logic signed [31:0] rd_data_r;

  logic signed [31:0] size_r [3];
  logic signed [31:0] org_r  [3];
  logic signed [31:0] c_r    [3];
  logic signed [44:0] cprod_r;
  logic signed [63:0] prod_r;
  logic               prod_v_r;
  logic [1:0]         prod_row_r;
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];
  logic               neg0_r, neg1_r;
  out_item_t          res_r;

  logic [1:0]         ax_k, ax_o;
  logic signed [12:0] span;
  logic signed [45:0] csum;
  logic signed [31:0] csat;
  logic [3:0]         wi;
  logic               d_v;
  logic signed [ACC_W-1:0] sh;
  logic [ACC_W-1:0]   mag0, mag1;
  logic [DIV_W-1:0]   num0, num1, den, q0, q1;
  logic               div_start, div_done, ok0, ok1;
  logic [26:0]        pix;

  vcp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num0  (num0),
    .num1  (num1),
    .den   (den),
    .done  (div_done),
    .q0    (q0),
    .q1    (q1)
  );

  // table read address per state
  always_comb begin
    rd_addr = '0;
    if (state_r == ST_CENT && step_r < 4'd6) rd_addr = ADDR_W'(SIZE_BASE) + ADDR_W'(step_r);
    else if (state_r == ST_MAC) rd_addr = ADDR_W'(cam_r * 12) + ADDR_W'(step_r);
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (state_r == ST_IDLE && !cmd_empty && !cmd.is_proj && cmd.wr_ok)
      mem[cmd.index] <= cmd.value;
  end

  // centre terms
  always_comb begin
    ax_k = step_r[1:0];
    ax_o = step_r[1:0] - 2'd1;
    case (ax_k)
      2'd0:    span = $signed({2'b0, cur_r.vx, 1'b0}) - $signed({2'b0, cfg.grid_x});
      2'd1:    span = $signed({2'b0, cur_r.vy, 1'b0}) - $signed({2'b0, cfg.grid_y});
      default: span = $signed({2'b0, cur_r.vz, 1'b0}) - $signed({2'b0, cfg.grid_z});
    endcase
    csum = 46'(cprod_r) + 46'($signed({org_r[ax_o], 1'b0}));
    if (csum > 46'sh7fffffff) csat = 32'sh7fffffff;
    else if (csum < -46'sh80000000) csat = -32'sh80000000;
    else csat = csum[31:0];
  end

  // mac word decode
  always_comb begin
    wi  = step_r - 4'd1;
    d_v = (state_r == ST_MAC) && (step_r >= 4'd1) && (step_r <= 4'd12);
    sh  = ACC_W'(prod_r >>> PROD_SHIFT);
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = acc_r[r];
      if (prod_v_r && prod_row_r == 2'(r)) acc_nxt[r] = acc_nxt[r] + sh;
      if (d_v && wi[1:0] == 2'd3 && wi[3:2] == 2'(r))
        acc_nxt[r] = acc_nxt[r] + ACC_W'(rd_data_r);
    end
  end

  // divide operands, rounding half away from zero
  always_comb begin
    mag0 = acc_r[0][ACC_W-1] ? ACC_W'(-acc_r[0]) : ACC_W'(acc_r[0]);
    mag1 = acc_r[1][ACC_W-1] ? ACC_W'(-acc_r[1]) : ACC_W'(acc_r[1]);
    num0 = DIV_W'({mag0, 1'b0}) + DIV_W'(acc_r[2]);
    num1 = DIV_W'({mag1, 1'b0}) + DIV_W'(acc_r[2]);
    den  = DIV_W'({acc_r[2], 1'b0});
    div_start = (state_r == ST_DEPTH) && !acc_r[2][ACC_W-1] && (acc_r[2] != '0);
    ok0 = (!neg0_r || q0 == '0) && (q0 < DIV_W'(cfg.width));
    ok1 = (!neg1_r || q1 == '0) && (q1 < DIV_W'(cfg.height));
    pix = 27'(q1[12:0]) * 27'(cfg.width) + 27'(q0[12:0]);
    cam_inc = cam_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 1'b1;
    cam_nxt   = cam_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.is_proj) state_nxt = ST_CENT;
        end
      end
      ST_CENT: begin
        if (step_r == 4'd6) begin
          state_nxt = ST_CCALC;
          step_nxt  = '0;
        end
      end
      ST_CCALC: begin
        if (step_r == 4'd3) begin
          step_nxt = '0;
          cam_nxt  = '0;
          state_nxt = (cams_r == '0) ? ST_EMIT : ST_MAC;
        end
      end
      ST_MAC: begin
        if (step_r == 4'd13) state_nxt = ST_DEPTH;
      end
      ST_DEPTH: begin
        step_nxt = '0;
        if (div_start) state_nxt = ST_DIV;
        else begin
          cam_nxt   = cam_inc;
          state_nxt = (cam_inc == cams_r) ? ST_EMIT : ST_MAC;
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        step_nxt = '0;
        if (ok0 && ok1) state_nxt = ST_PIX;
        else begin
          cam_nxt   = cam_inc;
          state_nxt = (cam_inc == cams_r) ? ST_EMIT : ST_MAC;
        end
      end
      ST_PIX: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      cam_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cam_r   <= cam_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_v_r <= 1'b0;
    if (state_r == ST_IDLE) begin
      cur_r  <= cmd;
      cams_r <= (cfg.cameras > CAM_W'(MAX_CAMERAS)) ? CAM_W'(MAX_CAMERAS) : CAM_W'(cfg.cameras);
      res_r  <= '0;
    end
    if (state_r == ST_CENT && step_r != '0) begin
      if (step_r <= 4'd3) size_r[2'(step_r - 4'd1)] <= rd_data_r;
      else org_r[2'(step_r - 4'd4)] <= rd_data_r;
    end
    if (state_r == ST_CCALC) begin
      if (step_r < 4'd3) cprod_r <= span * size_r[ax_k];
      if (step_r != '0) c_r[ax_o] <= csat;
    end
    if (state_r == ST_MAC) begin
      if (step_r == '0) begin
        for (int r = 0; r < 3; r++) acc_r[r] <= '0;
      end else begin
        for (int r = 0; r < 3; r++) acc_r[r] <= acc_nxt[r];
      end
      if (d_v && wi[1:0] != 2'd3) begin
        prod_r     <= 64'(rd_data_r) * 64'(c_r[wi[1:0]]);
        prod_row_r <= wi[3:2];
        prod_v_r   <= 1'b1;
      end
    end
    if (state_r == ST_DEPTH) begin
      neg0_r <= acc_r[0][ACC_W-1];
      neg1_r <= acc_r[1][ACC_W-1];
    end
    if (state_r == ST_PIX) begin
      res_r.hit          <= 1'b1;
      res_r.camera_index <= cam_r[2:0];
      res_r.pixel_index  <= pix[23:0];
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/core/voxel_camera_projection_lut.sv =====
// ----------------------------------------------------------------------------
// voxel_camera_projection_lut
// voxel centre projection through a table of per-camera matrices
// ----------------------------------------------------------------------------
// sequence: a write beat is stored while the back end is idle; a project beat
// takes the centre terms, then per camera tried the table walk and any divide
// throughput: one project beat at a time, held by the serial divider
// and the single-port table walk per camera
// reset: synchronous, clears queues, sequencer and config to defaults; the
// table is undefined until written
module voxel_camera_projection_lut import vcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t      cfg_r;
  logic      cmd_empty, cmd_pop, res_push, res_full;
  cmd_t      cmd;
  out_item_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_x  <= 11'd128;
      cfg_r.grid_y  <= 11'd128;
      cfg_r.grid_z  <= 11'd6;
      cfg_r.width   <= 13'd64;
      cfg_r.height  <= 13'd44;
      cfg_r.cameras <= 4'd6;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_X:  cfg_r.grid_x  <= cfg_data[10:0];
        CFG_GRID_Y:  cfg_r.grid_y  <= cfg_data[10:0];
        CFG_GRID_Z:  cfg_r.grid_z  <= cfg_data[10:0];
        CFG_WIDTH:   cfg_r.width   <= cfg_data[12:0];
        CFG_HEIGHT:  cfg_r.height  <= cfg_data[12:0];
        CFG_CAMERAS: cfg_r.cameras <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  vcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .data      (in_data),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  vcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  vcp_res_q u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (out_data)
  );

endmodule

// ===== rtl/core/vcp_checker.sv =====
// ----------------------------------------------------------------------------
// vcp_checker
// port-level checks of the projection block, bound to the top level
// ----------------------------------------------------------------------------
module vcp_checker import vcp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a miss carries zero camera and pixel
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.hit) |-> (out_data.camera_index == 3'd0 &&
                                       out_data.pixel_index == 24'd0))
    else $error("miss with nonzero fields");

  // a waiting result is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result lost while stalled");

  // a stalled result keeps its value
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind voxel_camera_projection_lut vcp_checker u_vcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of voxel_camera_projection_lut. Table words and
// project beats are pushed into the block while a local predictor works out
// hit, camera and pixel of every voxel. Each popped result is compared with
// the oldest prediction. The grid, image and camera settings change between
// phases, only while the block is idle. Sender and receiver idle at random,
// and at one point the receiver holds off while the sender keeps pushing, so the block stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import vcp_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 800;
  localparam int PHASE_ITEMS    = 78;
  localparam int IN_W           = $bits(in_item_t);

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  in_item_t    in_data;
  logic        out_empty;
  logic        out_pop;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  voxel_camera_projection_lut i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // predictor state
  longint      coef_table [TABLE_DEPTH];
  logic [10:0] grid_cnt [3];
  logic [12:0] img_w;
  logic [12:0] img_h;
  logic [3:0]  cam_cnt;

  out_item_t pending_results [$];
  int  send_idle;
  int  recv_idle;
  int  hold_req;
  int  quiet_cycles;
  bit  failed;

  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(0) - num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic out_item_t project_voxel(in_item_t it);
    longint    c [3];
    longint    acc [3];
    longint    t;
    longint    px;
    longint    py;
    int        cams;
    int        base;
    logic [9:0] vi [3];
    out_item_t r;
    vi[0] = it.voxel_x;
    vi[1] = it.voxel_y;
    vi[2] = it.voxel_z;
    for (int j = 0; j < 3; j++) begin
      t = (2 * longint'(vi[j]) - longint'(grid_cnt[j])) * coef_table[SIZE_BASE + j]
          + 2 * coef_table[ORIGIN_BASE + j];
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      c[j] = t;
    end
    r = '0;
    cams = (cam_cnt < MAX_CAMERAS) ? int'(cam_cnt) : MAX_CAMERAS;
    for (int cam = 0; cam < cams; cam++) begin
      for (int row = 0; row < 3; row++) begin
        base = cam * 12 + row * 4;
        acc[row] = coef_table[base + 3];
        for (int j = 0; j < 3; j++)
          acc[row] += (coef_table[base + j] * c[j]) >>> PROD_SHIFT;
      end
      if (acc[2] > 0) begin
        px = round_div(acc[0], acc[2]);
        py = round_div(acc[1], acc[2]);
        if (px >= 0 && py >= 0 && px < longint'(img_w) && py < longint'(img_h)) begin
          r.hit = 1'b1;
          r.camera_index = cam[2:0];
          r.pixel_index = 24'(py * longint'(img_w) + px);
          break;
        end
      end
    end
    return r;
  endfunction

  // table words that mostly land voxels inside the image
  function automatic logic [31:0] table_word(int idx);
    int row;
    int col;
    int span;
    int target;
    if ($urandom_range(9) == 0) return $urandom;
    if (idx >= ORIGIN_BASE) return $urandom_range(32768) - 16384;
    if (idx >= SIZE_BASE) return $urandom_range(4096, 1024);
    row = (idx % 12) / 4;
    col = idx % 4;
    if (col < 3) return (row == 2) ? $urandom_range(512) - 256 : $urandom_range(4096) - 2048;
    if (row == 2) begin
      case ($urandom_range(7))
        0: return 32'd0;
        1: return -($urandom_range(3, 1) << FRAC_BITS);
        default: return $urandom_range(2, 1) << FRAC_BITS;
      endcase
    end
    span = (row == 0) ? int'(img_w) : int'(img_h);
    target = $urandom_range(span + span / 4) - span / 8;
    return target << FRAC_BITS;
  endfunction

  task automatic send_item(input in_item_t it);
    bit taken;
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    forever begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
      if (taken) break;
    end
    if (it.operation == OP_PROJECT)
      pending_results = {pending_results, project_voxel(it)};
    else if (it.table_index < TABLE_DEPTH)
      coef_table[it.table_index] = longint'(it.table_value);
  endtask

  task automatic write_word(input int idx, input logic [31:0] value);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.operation = OP_WRITE;
    it.table_index = idx[6:0];
    it.table_value = value;
    send_item(it);
  endtask

  task automatic project(input logic [9:0] x, input logic [9:0] y, input logic [9:0] z);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.operation = OP_PROJECT;
    it.voxel_x = x;
    it.voxel_y = y;
    it.voxel_z = z;
    send_item(it);
  endtask

  task automatic send_random();
    int sel;
    int idx;
    sel = $urandom_range(99);
    if (sel < 15) begin
      idx = $urandom_range(TABLE_DEPTH - 1);
      write_word(idx, table_word(idx));
    end else if (sel < 18)
      write_word($urandom_range(127, TABLE_DEPTH), $urandom);
    else if (sel < 85)
      project(10'($urandom_range(grid_cnt[0] > 1023 ? 1023 : grid_cnt[0])),
              10'($urandom_range(grid_cnt[1] > 1023 ? 1023 : grid_cnt[1])),
              10'($urandom_range(grid_cnt[2] > 1023 ? 1023 : grid_cnt[2])));
    else
      project(10'($urandom), 10'($urandom), 10'($urandom));
  endtask

  task automatic load_table();
    for (int i = 0; i < TABLE_DEPTH; i++)
      write_word(i, table_word(i));
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] value, input int w);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (value & ((32'd1 << w) - 1)) | ($urandom & ~((32'd1 << w) - 1));
    forever begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
      if (taken) break;
    end
    case (idx)
      CFG_GRID_X:  grid_cnt[0] = value[10:0];
      CFG_GRID_Y:  grid_cnt[1] = value[10:0];
      CFG_GRID_Z:  grid_cnt[2] = value[10:0];
      CFG_WIDTH:   img_w = value[12:0];
      CFG_HEIGHT:  img_h = value[12:0];
      CFG_CAMERAS: cam_cnt = value[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    load_table();
    write_word(TABLE_DEPTH, $urandom);
    write_word(127, $urandom);
    project(10'd0, 10'd0, 10'd0);
    project(10'd1023, 10'd1023, 10'd1023);
    project(10'd64, 10'd64, 10'd3);
    write_word(SIZE_BASE, 32'h7fffffff);
    write_word(ORIGIN_BASE, 32'h80000000);
    project(10'd1023, 10'd0, 10'd5);
    project(10'd0, 10'd1023, 10'd0);
    write_word(0, 32'h80000000);
    write_word(3, 32'h7fffffff);
    write_word(10, 32'd0);
    write_word(11, 32'd0);
    project(10'd5, 10'd5, 10'd1);
    write_word(SIZE_BASE, 32'd2048);
    write_word(ORIGIN_BASE, 32'd0);
    write_word(0, 32'd0);
    write_word(3, 32'd32 << FRAC_BITS);
    project(10'd64, 10'd64, 10'd3);
    project(10'd127, 10'd127, 10'd5);
  endtask

  task automatic test_settings();
    logic [31:0] s [8][6] = '{
      '{128, 128, 6, 64, 44, 2},
      '{1, 1, 1, 1, 1, 1},
      '{1024, 1024, 1024, 4096, 4096, 3},
      '{2047, 16, 0, 8191, 8191, 2},
      '{200, 100, 8, 640, 480, 0},
      '{64, 64, 4, 0, 100, 2},
      '{300, 300, 10, 320, 240, 8},
      '{128, 128, 6, 64, 44, 15}
    };
    int widths [6] = '{11, 11, 11, 13, 13, 4};
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      if (p < 3) begin
        send_idle = 35;
        recv_idle = 85;
      end else if (p < 6) begin
        send_idle = 85;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int r = 0; r < 6; r++)
        write_cfg(r[2:0], s[p][r], widths[r]);
      cfg_valid <= 1'b0;
      load_table();
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_random();
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_cfg(CFG_CAMERAS, 32'd1, 4);
    cfg_valid <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1;
    for (int n = 0; n < 40; n++)
      project(10'($urandom_range(127)), 10'($urandom_range(127)), 10'($urandom_range(5)));
  endtask

  // result side
  initial begin
    bit        fire;
    out_item_t got;
    out_item_t want;
    int        hold_cnt;
    hold_cnt = 0;
    out_pop <= 1'b0;
    forever begin
      @(negedge clk);
      fire = out_pop && !out_empty;
      got = out_data;
      @(posedge clk);
      if (fire) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit expected %0d actual %0d", want.hit, got.hit);
            failed = 1'b1;
          end
          if (got.camera_index !== want.camera_index) begin
            $error("camera_index expected %0d actual %0d", want.camera_index, got.camera_index);
            failed = 1'b1;
          end
          if (got.pixel_index !== want.pixel_index) begin
            $error("pixel_index expected %0d actual %0d", want.pixel_index, got.pixel_index);
            failed = 1'b1;
          end
        end
      end
      if (hold_req != 0) begin
        hold_req = 0;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(negedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("voxel_camera_projection_lut verification failed");
      $finish;
    end
  end

  initial begin
    failed = 1'b0;
    hold_req = 0;
    send_idle = 35;
    recv_idle = 85;
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_GRID_X;
    cfg_data <= '0;
    for (int i = 0; i < TABLE_DEPTH; i++)
      coef_table[i] = 0;
    grid_cnt[0] = 11'd128;
    grid_cnt[1] = 11'd128;
    grid_cnt[2] = 11'd6;
    img_w = 13'd64;
    img_h = 13'd44;
    cam_cnt = 4'd6;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    test_backpressure();
    wait_idle();
    if (!failed)
      $display("voxel_camera_projection_lut verification clean");
    else
      $display("voxel_camera_projection_lut verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/vcp_pkg.sv
rtl/core/vcp_front.sv
rtl/core/vcp_div.sv
rtl/core/vcp_res_q.sv
rtl/core/vcp_back.sv
rtl/core/voxel_camera_projection_lut.sv
rtl/core/vcp_checker.sv
tb/sv/tb.sv
